### rtl/core/acsr_pkg.sv
// Shared types, constants and register codes of the anti-aliased circle span rasterizer.
`default_nettype none

package acsr_pkg;

  // Default upper bound of the diameter clamp.
  localparam int MAX_DIAMETER_DEFAULT = 64;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_DISC_DIAMETER    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_COLOR = 3'd4;

  // Register reset values.
  localparam logic [6:0]  DIAMETER_RESET   = 7'd12;
  localparam logic [11:0] ORIGIN_RESET     = 12'd0;
  localparam logic [31:0] COLOR_RESET      = 32'd0;

  // Shading constants.
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hff;
  localparam logic [8:0]  RIM_WEIGHT    = 9'd45;
  localparam logic [8:0]  BLEND_ONE     = 9'd256;
  localparam logic [16:0] BLEND_ROUND   = 17'd128;
  localparam logic [8:0]  INNER_INSET   = 9'd5;
  localparam logic [6:0]  MIN_DIAMETER  = 7'd3;

  // Sequencing constants.
  localparam logic [3:0] SAMPLE_LAST  = 4'd15;
  localparam int         DIVIDEND_W   = 13;
  localparam logic [3:0] DIV_STEPS    = 4'd13;
  localparam logic [1:0] CHAN_LAST    = 2'd2;

  // Which blend the channel-serial blender performs.
  typedef enum logic [1:0] {
    PASS_RIM,
    PASS_BODY,
    PASS_FINAL
  } blend_pass_t;

  // Configuration register set.
  typedef struct packed {
    logic [6:0]  disc_diameter;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [31:0] fill_color;
    logic [31:0] background_color;
  } acsr_cfg_t;

  // One input request.
  typedef struct packed {
    logic [5:0] pixel_col;
    logic [5:0] pixel_row;
  } pixel_in_t;

  // One output request.
  typedef struct packed {
    logic [12:0] run_x;
    logic [12:0] run_y;
    logic [6:0]  run_length;
    logic [31:0] run_color;
    logic        last;
  } run_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        prep;
    logic        sample;
    logic [3:0]  sample_idx;
    logic        div_start;
    logic        div_step;
    logic        blend;
    blend_pass_t blend_pass;
    logic [1:0]  blend_chan;
    logic        resolve;
  } acsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic out_empty;
  } acsr_status_t;

endpackage

`default_nettype wire

### rtl/core/acsr_ctrl.sv
// Controller state machine that sequences sampling, division, blending and run update.
`default_nettype none

module acsr_ctrl
  import acsr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire acsr_status_t status,
  output acsr_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SAMPLE,
    S_SETTLE,
    S_DIVIDE,
    S_BLEND,
    S_RESOLVE
  } state_t;

  state_t      state;
  logic [3:0]  step;
  blend_pass_t pass;
  logic [1:0]  chan;

  // State, step counter and blend position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      pass  <= PASS_RIM;
      chan  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && !status.skip) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_SAMPLE;
          step  <= '0;
        end
        S_SAMPLE: begin
          if (step == SAMPLE_LAST) begin
            state <= S_SETTLE;
          end
          step <= step + 4'd1;
        end
        S_SETTLE: begin
          state <= S_DIVIDE;
          step  <= '0;
        end
        S_DIVIDE: begin
          if (step == DIV_STEPS) begin
            state <= S_BLEND;
            pass  <= PASS_RIM;
            chan  <= '0;
          end
          step <= step + 4'd1;
        end
        S_BLEND: begin
          if (chan == CHAN_LAST) begin
            chan <= '0;
            case (pass)
              PASS_RIM:   pass <= PASS_BODY;
              PASS_BODY:  pass <= PASS_FINAL;
              default: begin
                pass  <= PASS_RIM;
                state <= S_RESOLVE;
              end
            endcase
          end else begin
            chan <= chan + 2'd1;
          end
        end
        S_RESOLVE: begin
          if (status.out_empty) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new request is taken only between items.
  assign in_ready = (state == S_IDLE);

  // Commands decoded from the current state.
  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.prep       = (state == S_PREP);
    cmd.sample     = (state == S_SAMPLE);
    cmd.sample_idx = step;
    cmd.div_start  = (state == S_DIVIDE) && (step == 4'd0);
    cmd.div_step   = (state == S_DIVIDE) && (step != 4'd0);
    cmd.blend      = (state == S_BLEND);
    cmd.blend_pass = pass;
    cmd.blend_chan = chan;
    cmd.resolve    = (state == S_RESOLVE) && status.out_empty;
  end

endmodule

`default_nettype wire

### rtl/core/acsr_datapath.sv
// Datapath: sample counting, coverage divider, channel-serial blender, run merge and output buffer.
`default_nettype none

module acsr_datapath
  import acsr_pkg::*;
#(
  parameter int MAX_DIAMETER = MAX_DIAMETER_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire acsr_cfg_t    cfg,
  input  wire pixel_in_t    in_data,
  input  wire acsr_cmd_t    cmd,
  output acsr_status_t      status,
  output logic              out_valid,
  input  wire logic         out_ready,
  output run_out_t          out_data
);

  // Effective diameter after the clamp.
  logic [6:0] diam;
  assign diam = ({1'b0, cfg.disc_diameter} > 8'(MAX_DIAMETER)) ? 7'(MAX_DIAMETER)
                                                              : cfg.disc_diameter;

  // Requests outside the square, or with a tiny disc, produce nothing.
  assign status.skip = (diam < MIN_DIAMETER) || ({1'b0, in_data.pixel_col} >= diam) ||
                       ({1'b0, in_data.pixel_row} >= diam);

  // Captured pixel position.
  logic [5:0] col;
  logic [5:0] row;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col <= in_data.pixel_col;
      row <= in_data.pixel_row;
    end
  end

  // Squared radii of the outer and inner discs.
  logic [8:0]  radius;
  logic [8:0]  inner;
  logic [17:0] radius_sq;
  logic [17:0] inner_sq;
  assign radius = {diam, 2'b00};
  assign inner  = radius - INNER_INSET;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      radius_sq <= {9'd0, radius} * {9'd0, radius};
      inner_sq  <= {9'd0, inner} * {9'd0, inner};
    end
  end

  // Sample offsets from the disc center, one sample per cycle.
  logic [8:0]  pos_x;
  logic [8:0]  pos_y;
  logic [9:0]  dx;
  logic [9:0]  dy;
  logic [8:0]  abs_dx;
  logic [8:0]  abs_dy;
  logic [17:0] sq_x;
  logic [17:0] sq_y;
  logic        sq_valid;
  logic [18:0] dist_sq;
  logic [4:0]  cov;
  logic [4:0]  fil;

  assign pos_x   = {col, cmd.sample_idx[1:0], 1'b1};
  assign pos_y   = {row, cmd.sample_idx[3:2], 1'b1};
  assign dx      = {1'b0, pos_x} - {1'b0, radius};
  assign dy      = {1'b0, pos_y} - {1'b0, radius};
  assign abs_dx  = dx[9] ? 9'(-dx) : dx[8:0];
  assign abs_dy  = dy[9] ? 9'(-dy) : dy[8:0];
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    sq_x <= {9'd0, abs_dx} * {9'd0, abs_dx};
    sq_y <= {9'd0, abs_dy} * {9'd0, abs_dy};
  end

  // Squares follow the sample command in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= cmd.sample;
    end
  end

  // Coverage and inner-disc counts.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cov <= '0;
      fil <= '0;
    end else if (sq_valid) begin
      cov <= cov + 5'(dist_sq <= {1'b0, radius_sq});
      fil <= fil + 5'(dist_sq <= {1'b0, inner_sq});
    end
  end

  // Restoring divider for fil * 256 / cov, one quotient bit per cycle.
  logic [4:0]            rem;
  logic [DIVIDEND_W-1:0] quot;
  logic [5:0]            rem_shift;
  logic                  fits;
  assign rem_shift = {rem, quot[DIVIDEND_W-1]};
  assign fits      = (rem_shift >= {1'b0, cov});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= '0;
      quot <= {fil, 8'd0};
    end else if (cmd.div_step) begin
      rem  <= fits ? 5'(rem_shift - {1'b0, cov}) : rem_shift[4:0];
      quot <= {quot[DIVIDEND_W-2:0], fits};
    end
  end

  // Channel-serial blender: (a * (256 - w) + b * w + 128) / 256.
  logic [2:0][7:0] fill_rgb;
  logic [2:0][7:0] bg_rgb;
  logic [2:0][7:0] rim_rgb;
  logic [2:0][7:0] body_rgb;
  logic [2:0][7:0] final_rgb;
  logic [7:0]      op_a;
  logic [7:0]      op_b;
  logic [8:0]      weight;
  logic [8:0]      weight_inv;
  logic [16:0]     mix;

  assign fill_rgb = cfg.fill_color[23:0];
  assign bg_rgb   = cfg.background_color[23:0];

  always_comb begin
    case (cmd.blend_pass)
      PASS_RIM: begin
        op_a   = fill_rgb[cmd.blend_chan];
        op_b   = 8'd0;
        weight = RIM_WEIGHT;
      end
      PASS_BODY: begin
        op_a   = rim_rgb[cmd.blend_chan];
        op_b   = fill_rgb[cmd.blend_chan];
        weight = quot[8:0];
      end
      default: begin
        op_a   = bg_rgb[cmd.blend_chan];
        op_b   = body_rgb[cmd.blend_chan];
        weight = {cov, 4'd0};
      end
    endcase
  end

  assign weight_inv = BLEND_ONE - weight;
  assign mix = ({9'd0, op_a} * {8'd0, weight_inv}) + ({9'd0, op_b} * {8'd0, weight}) +
               BLEND_ROUND;

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      case (cmd.blend_pass)
        PASS_RIM:  rim_rgb[cmd.blend_chan]   <= mix[15:8];
        PASS_BODY: body_rgb[cmd.blend_chan]  <= mix[15:8];
        default:   final_rgb[cmd.blend_chan] <= mix[15:8];
      endcase
    end
  end

  // Shaded pixel: background when no sample falls inside the disc.
  logic [31:0] pix;
  assign pix = (cov == 5'd0) ? cfg.background_color : {ALPHA_OPAQUE, final_rgb};

  // Run merge state.
  logic [31:0] prev_pixel;
  logic [5:0]  run_start;
  logic [31:0] prev_eff;
  logic [5:0]  start_eff;
  logic        first_col;
  logic        changed;
  logic        has_closed;
  logic        has_final;
  logic [5:0]  new_start;
  run_out_t    closed_run;
  run_out_t    final_run;
  logic [12:0] run_y;

  assign first_col  = (col == 6'd0);
  assign prev_eff   = first_col ? cfg.background_color : prev_pixel;
  assign start_eff  = first_col ? 6'd0 : run_start;
  assign changed    = !first_col && (pix != prev_eff);
  assign has_closed = changed && (prev_eff != cfg.background_color);
  assign new_start  = changed ? col : start_eff;
  assign has_final  = ({1'b0, col} == (diam - 7'd1)) && (pix != cfg.background_color);
  assign run_y      = {1'b0, cfg.origin_y} + {7'd0, row};

  always_comb begin
    closed_run.run_x      = {1'b0, cfg.origin_x} + {7'd0, start_eff};
    closed_run.run_y      = run_y;
    closed_run.run_length = {1'b0, col} - {1'b0, start_eff};
    closed_run.run_color  = prev_eff;
    closed_run.last       = !has_final;
    final_run.run_x       = {1'b0, cfg.origin_x} + {7'd0, new_start};
    final_run.run_y       = run_y;
    final_run.run_length  = diam - {1'b0, new_start};
    final_run.run_color   = pix;
    final_run.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pixel <= COLOR_RESET;
      run_start  <= '0;
    end else if (cmd.resolve) begin
      prev_pixel <= pix;
      run_start  <= new_start;
    end
  end

  // Two-entry output buffer; the head entry drives the port.
  run_out_t   res_head;
  run_out_t   res_tail;
  logic [1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= '0;
    end else if (cmd.resolve) begin
      out_count <= 2'(has_closed) + 2'(has_final);
    end else if (out_valid && out_ready) begin
      out_count <= out_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      res_head <= has_closed ? closed_run : final_run;
      res_tail <= final_run;
    end else if (out_valid && out_ready) begin
      res_head <= res_tail;
    end
  end

  assign out_valid        = (out_count != 2'd0);
  assign out_data         = res_head;
  assign status.out_empty = (out_count == 2'd0);

endmodule

`default_nettype wire

### rtl/core/antialiased_circle_span_raster_top.sv
// Top level of the anti-aliased circle span rasterizer: configuration registers and core.
`default_nettype none

// Each pixel request of the disc's bounding square goes, from acceptance to its
// runs being ready, through these steps before a new request is taken:
// a setup step for the squared radii, the 4x4 supersampling grid through
// one pair of squarers plus a settle step for the counts, the bit-serial
// divider that forms the inner fraction, the channel-serial blender (rim,
// body and final mix over three channels) and the run update.
// Requests outside the square or with a diameter below three are taken
// without leaving the idle state and produce nothing. A pixel yields zero,
// one or two runs; the next request is taken while earlier runs still wait
// at the output, and the run update holds until that buffer has drained.
// Configuration writes are expected only while the block is idle.
module antialiased_circle_span_raster_top
  import acsr_pkg::*;
#(
  parameter int MAX_DIAMETER = MAX_DIAMETER_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire pixel_in_t              in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output run_out_t                    out_data
);

  acsr_cfg_t    cfg;
  acsr_cmd_t    cmd;
  acsr_status_t status;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disc_diameter    <= DIAMETER_RESET;
      cfg.origin_x         <= ORIGIN_RESET;
      cfg.origin_y         <= ORIGIN_RESET;
      cfg.fill_color       <= COLOR_RESET;
      cfg.background_color <= COLOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DISC_DIAMETER:    cfg.disc_diameter    <= cfg_data[6:0];
        REG_ORIGIN_X:         cfg.origin_x         <= cfg_data[11:0];
        REG_ORIGIN_Y:         cfg.origin_y         <= cfg_data[11:0];
        REG_FILL_COLOR:       cfg.fill_color       <= cfg_data;
        REG_BACKGROUND_COLOR: cfg.background_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  acsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, run merge and output buffer.
  acsr_datapath #(
    .MAX_DIAMETER (MAX_DIAMETER)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
